FILE: src/mfsh_pkg.sv
package mfsh_pkg;

   // hash constants
   localparam logic [31:0] MixMul    = 32'h5bd1e995;
   localparam int          MixShift  = 24;
   localparam int          FinShiftA = 13;
   localparam int          FinShiftB = 15;
   localparam logic [31:0] SeedReset = 32'd1;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_MIX_A,
      S_MIX_B,
      S_MIX_C,
      S_FIN_A,
      S_FIN_B,
      S_FIN_C
   } state_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MIX_A,
      OP_MIX_B,
      OP_MIX_C,
      OP_FIN_A,
      OP_FIN_B,
      OP_FIN_C
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic need_mix;   // accepted item completes a word
      logic last_now;   // accepted item carries last
      logic last_held;  // item in progress carries last
      logic out_busy;   // result register full and not taken
   } status_type;

endpackage

FILE: src/mfsh_req_if.sv
interface mfsh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        skip;
   logic        first;
   logic        last;
   logic [31:0] total_length;

   modport source (output valid, output data_byte, output skip, output first,
                   output last, output total_length, input ready);
   modport sink (input valid, input data_byte, input skip, input first,
                 input last, input total_length, output ready);
endinterface

FILE: src/mfsh_rsp_if.sv
interface mfsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface

FILE: src/mfsh_ctrl.sv
module mfsh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mfsh_pkg::status_type status,
   output mfsh_pkg::cmd_type    cmd
);

   mfsh_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfsh_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfsh_pkg::S_IDLE: begin
            if (req_valid) begin
               if (status.need_mix) begin
                  state_in = mfsh_pkg::S_MIX_A;
               end else if (status.last_now) begin
                  state_in = mfsh_pkg::S_FIN_A;
               end
            end
         end
         mfsh_pkg::S_MIX_A: state_in = mfsh_pkg::S_MIX_B;
         mfsh_pkg::S_MIX_B: state_in = mfsh_pkg::S_MIX_C;
         mfsh_pkg::S_MIX_C: begin
            state_in = status.last_held ? mfsh_pkg::S_FIN_A : mfsh_pkg::S_IDLE;
         end
         mfsh_pkg::S_FIN_A: state_in = mfsh_pkg::S_FIN_B;
         mfsh_pkg::S_FIN_B: state_in = mfsh_pkg::S_FIN_C;
         mfsh_pkg::S_FIN_C: begin
            if (!status.out_busy) begin
               state_in = mfsh_pkg::S_IDLE;
            end
         end
         default: state_in = mfsh_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = mfsh_pkg::OP_NONE;
      case (state_ff)
         mfsh_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = mfsh_pkg::OP_ACCEPT;
            end
         end
         mfsh_pkg::S_MIX_A: cmd.op = mfsh_pkg::OP_MIX_A;
         mfsh_pkg::S_MIX_B: cmd.op = mfsh_pkg::OP_MIX_B;
         mfsh_pkg::S_MIX_C: cmd.op = mfsh_pkg::OP_MIX_C;
         mfsh_pkg::S_FIN_A: cmd.op = mfsh_pkg::OP_FIN_A;
         mfsh_pkg::S_FIN_B: cmd.op = mfsh_pkg::OP_FIN_B;
         mfsh_pkg::S_FIN_C: begin
            if (!status.out_busy) begin
               cmd.op = mfsh_pkg::OP_FIN_C;
            end
         end
         default: cmd.op = mfsh_pkg::OP_NONE;
      endcase
   end

endmodule

FILE: src/mfsh_dp.sv
module mfsh_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_skip,
   input  logic                 req_first,
   input  logic                 req_last,
   input  logic [31:0]          req_total_length,
   mfsh_rsp_if.source           rsp_if,
   input  mfsh_pkg::cmd_type    cmd,
   output mfsh_pkg::status_type status
);

   logic [31:0] seed_ff;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] rem_ff, rem_in;
   logic [23:0] gather_ff, gather_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] word_ff, word_in;
   logic        last_ff, last_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;

   logic [31:0] hash_start;
   logic [31:0] rem_start;
   logic [23:0] gather_start;
   logic [1:0]  pos_start;
   logic        take;
   logic [1:0]  tail_n;
   logic [31:0] tail_hash;
   logic [31:0] fin_c_hash;
   logic [31:0] mul_a;
   logic [31:0] mul_p;

   // seed register
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mfsh_pkg::SeedReset;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // start of message applied ahead of the byte
   always_comb begin
      hash_start   = req_first ? (seed_ff ^ req_total_length) : hash_ff;
      rem_start    = req_first ? req_total_length : rem_ff;
      gather_start = req_first ? 24'd0 : gather_ff;
      pos_start    = req_first ? 2'd0 : pos_ff;
      take         = !req_skip && ({30'd0, pos_start} < rem_start);
   end

   // tail fold selection
   always_comb begin
      tail_n    = (rem_ff < 32'd4) ? rem_ff[1:0] : 2'd3;
      tail_hash = hash_ff;
      if (tail_n == 2'd3) begin
         tail_hash = tail_hash ^ {8'd0, gather_ff[23:16], 16'd0};
      end
      if (tail_n >= 2'd2) begin
         tail_hash = tail_hash ^ {16'd0, gather_ff[15:8], 8'd0};
      end
      if (tail_n >= 2'd1) begin
         tail_hash = tail_hash ^ {24'd0, gather_ff[7:0]};
      end
      fin_c_hash = hash_ff ^ (hash_ff >> mfsh_pkg::FinShiftB);
   end

   // shared multiplier by the mix constant
   always_comb begin
      case (cmd.op)
         mfsh_pkg::OP_MIX_A: mul_a = word_ff;
         mfsh_pkg::OP_MIX_B: mul_a = word_ff ^ (word_ff >> mfsh_pkg::MixShift);
         mfsh_pkg::OP_MIX_C: mul_a = hash_ff;
         mfsh_pkg::OP_FIN_A: mul_a = tail_hash;
         mfsh_pkg::OP_FIN_B: mul_a = hash_ff ^ (hash_ff >> mfsh_pkg::FinShiftA);
         default:            mul_a = hash_ff;
      endcase
      mul_p = mul_a * mfsh_pkg::MixMul;
   end

   // datapath next values
   always_comb begin
      hash_in      = hash_ff;
      rem_in       = rem_ff;
      gather_in    = gather_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      case (cmd.op)
         mfsh_pkg::OP_ACCEPT: begin
            hash_in   = hash_start;
            rem_in    = rem_start;
            gather_in = gather_start;
            pos_in    = pos_start;
            last_in   = req_last;
            if (take) begin
               case (pos_start)
                  2'd0: begin
                     gather_in = {gather_start[23:8], req_data_byte};
                     pos_in    = 2'd1;
                  end
                  2'd1: begin
                     gather_in = {gather_start[23:16], req_data_byte,
                                  gather_start[7:0]};
                     pos_in    = 2'd2;
                  end
                  2'd2: begin
                     gather_in = {req_data_byte, gather_start[15:0]};
                     pos_in    = 2'd3;
                  end
                  default: begin
                     word_in   = {req_data_byte, gather_start};
                     rem_in    = rem_start - 32'd4;
                     gather_in = 24'd0;
                     pos_in    = 2'd0;
                  end
               endcase
            end
         end
         mfsh_pkg::OP_MIX_A: word_in = mul_p;
         mfsh_pkg::OP_MIX_B: word_in = mul_p;
         mfsh_pkg::OP_MIX_C: hash_in = mul_p ^ word_ff;
         mfsh_pkg::OP_FIN_A: hash_in = (tail_n != 2'd0) ? mul_p : tail_hash;
         mfsh_pkg::OP_FIN_B: hash_in = mul_p;
         mfsh_pkg::OP_FIN_C: begin
            hash_in      = fin_c_hash;
            rem_in       = 32'd0;
            gather_in    = 24'd0;
            pos_in       = 2'd0;
            last_in      = 1'b0;
            out_data_in  = fin_c_hash;
            out_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= 32'd0;
         rem_ff       <= 32'd0;
         gather_ff    <= 24'd0;
         pos_ff       <= 2'd0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         rem_ff       <= rem_in;
         gather_ff    <= gather_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
   end

   // status to controller
   always_comb begin
      status.need_mix  = take && (pos_start == 2'd3);
      status.last_now  = req_last;
      status.last_held = last_ff;
      status.out_busy  = out_valid_ff && !rsp_if.ready;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.hash_value = out_data_ff;

endmodule

FILE: src/murmur2_filtered_stream_hash_top.sv
// Streaming 32-bit MurmurHash2 over bytes, one byte per item, with a skip flag per
// byte. The item with first set starts a message: the hash begins as seed XOR
// total_length, and only that many kept bytes are hashed, any further kept bytes
// being ignored. The item with last set folds in the tail bytes, runs the final
// avalanche and gives one hash_value. An item that does not complete a 32-bit word
// is taken alone; one that does adds three steps through the single shared
// multiplier by the mix constant, and a last item three more (tail fold, avalanche
// multiply, final shift), the last waiting while the result register holds an
// untaken hash. The user must write the seed through csr_wr_en and csr_wr_data
// only while no item is in flight; the block itself does not enforce this.
module murmur2_filtered_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   mfsh_req_if.sink    req_if,
   mfsh_rsp_if.source  rsp_if
);

   mfsh_pkg::cmd_type    cmd;
   mfsh_pkg::status_type status;

   // sequencer
   mfsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hash datapath
   mfsh_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_data_byte    (req_if.data_byte),
      .req_skip         (req_if.skip),
      .req_first        (req_if.first),
      .req_last         (req_if.last),
      .req_total_length (req_if.total_length),
      .rsp_if           (rsp_if),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
